FILE: src/lmbps_pkg.sv
`default_nettype none
package lmbps_pkg;

  localparam int COLOR_BITS = 11;
  localparam int PIX_W = 3 * COLOR_BITS;
  localparam int PLANE_W = 4;
  localparam int ROW_ADDR_W = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FLIP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_POL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LATCH_POL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_POL = 3'd4;

  typedef struct packed {
    logic [1:0]            command;
    logic [5:0]            column;
    logic [5:0]            row;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } req_t;

  typedef struct packed {
    logic                  top_red;
    logic                  top_green;
    logic                  top_blue;
    logic                  bottom_red;
    logic                  bottom_green;
    logic                  bottom_blue;
    logic                  shift_clock;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  latch;
    logic                  output_enable;
  } res_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] columns_in_use;
    logic [CFG_DATA_W-1:0] rows_in_use;
    logic                  clock_active_high;
    logic                  latch_active_high;
    logic                  enable_active_high;
  } cfg_t;

  // one queued operation between front and back end
  typedef struct packed {
    logic [1:0]       cmd;
    logic [5:0]       row;
    logic [5:0]       column;
    logic [PIX_W-1:0] pixel;
  } op_t;

endpackage
`default_nettype wire

FILE: src/lmbps_fifo.sv
`default_nettype none
module lmbps_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: src/lmbps_front.sv
`default_nettype none
module lmbps_front #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  lmbps_pkg::req_t                req,
  input  logic                           busy,
  input  logic [$clog2(MAX_COLUMNS):0]   eff_cols,
  input  logic [$clog2(MAX_ROWS)-1:0]    half_rows,
  output lmbps_pkg::op_t                 op,
  output logic                           op_valid,
  input  logic                           op_pop
);
  import lmbps_pkg::*;

  logic q_full;
  logic q_empty;
  logic keep;
  logic in_panel;
  logic q_push;
  op_t  q_in;

  assign in_panel = (32'(req.column) < 32'(eff_cols)) &&
                    (32'(req.row) < 32'({half_rows, 1'b0}));

  // writes outside the panel and unknown commands are dropped here
  always_comb begin
    case (req.command)
      CMD_WRITE: keep = in_panel;
      CMD_FLIP:  keep = 1'b1;
      CMD_TICK:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  always_comb begin
    q_in.cmd    = req.command;
    q_in.row    = req.row;
    q_in.column = req.column;
    q_in.pixel  = {req.blue, req.green, req.red};
  end

  assign full     = busy || q_full;
  assign q_push   = push && !full && keep;
  assign op_valid = !q_empty;

  lmbps_fifo #(
    .T     (op_t),
    .DEPTH (2)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (op_pop),
    .rdata (op),
    .empty (q_empty)
  );

endmodule
`default_nettype wire

FILE: src/lmbps_back.sv
`default_nettype none
module lmbps_back #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lmbps_pkg::cfg_t                cfg,
  input  logic [$clog2(MAX_COLUMNS):0]   eff_cols,
  input  logic [$clog2(MAX_ROWS)-1:0]    half_rows,
  input  lmbps_pkg::op_t                 op,
  input  logic                           op_valid,
  output logic                           op_pop,
  output lmbps_pkg::res_t                res,
  output logic                           res_push,
  input  logic                           res_full,
  output logic                           busy
);
  import lmbps_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int PW = RW - 1;
  localparam int AW = CW + RW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  localparam logic [1:0] PH_LOW = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DISPLAY = 2'd2;
  localparam logic [1:0] PH_BLANK = 2'd3;

  function automatic logic [2:0] plane_bits(input logic [PIX_W-1:0] px,
                                            input logic [PLANE_W-1:0] p);
    logic [COLOR_BITS-1:0] r;
    logic [COLOR_BITS-1:0] g;
    logic [COLOR_BITS-1:0] b;
    r = px[COLOR_BITS-1:0];
    g = px[2*COLOR_BITS-1:COLOR_BITS];
    b = px[3*COLOR_BITS-1:2*COLOR_BITS];
    return {b[p], g[p], r[p]};
  endfunction

  logic [1:0]            state, state_next;
  logic [AW:0]           idx, idx_next;
  logic                  cp_wr, cp_wr_next;
  logic [AW-1:0]         cp_wr_addr;
  logic                  flip, flip_next;
  logic [PLANE_W-1:0]    plane, plane_next;
  logic [PW-1:0]         row_pair, row_pair_next;
  logic [CW-1:0]         col, col_next;
  logic [1:0]            phase, phase_next;
  logic [COLOR_BITS-1:0] disp, disp_next;
  logic [5:0]            held_data, held_data_next;
  logic [ROW_ADDR_W-1:0] held_row, held_row_next;
  logic                  fresh;

  logic [PIX_W-1:0]      front_mem [DEPTH];
  logic [PIX_W-1:0]      back_mem [DEPTH];
  logic [PIX_W-1:0]      front_rd;
  logic [PIX_W-1:0]      top_rd;
  logic [PIX_W-1:0]      bot_rd;
  logic [AW-1:0]         rd_top_q;
  logic [AW-1:0]         rd_bot_q;

  logic                  fw_en;
  logic [AW-1:0]         fw_addr;
  logic [PIX_W-1:0]      fw_data;
  logic                  bw_en;
  logic [AW-1:0]         bw_addr;
  logic [PIX_W-1:0]      bw_data;

  logic [RW-1:0]         bot_row, bot_row_pre;
  logic [AW-1:0]         need_top, need_bot;
  logic [AW-1:0]         pre_top, pre_bot;
  logic                  data_ok;

  logic [CW:0]           col_inc;
  logic [COLOR_BITS:0]   disp_inc;
  logic [COLOR_BITS:0]   plane_weight;
  logic [RW-1:0]         row_inc;
  logic                  clk_act, lat_act, oe_act;

  assign busy = (state == ST_CLEAR);

  // back-store addresses for the current counters and, prefetched, for the next ones
  assign bot_row     = RW'(row_pair) + half_rows;
  assign bot_row_pre = RW'(row_pair_next) + half_rows;
  assign need_top    = {RW'(row_pair), col};
  assign need_bot    = {bot_row, col};
  assign pre_top     = {RW'(row_pair_next), col_next};
  assign pre_bot     = {bot_row_pre, col_next};
  assign data_ok     = fresh && (rd_top_q == need_top) && (rd_bot_q == need_bot);

  assign col_inc      = {1'b0, col} + 1'b1;
  assign disp_inc     = {1'b0, disp} + 1'b1;
  assign plane_weight = (COLOR_BITS + 1)'(1) << plane;
  assign row_inc      = {1'b0, row_pair} + 1'b1;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cp_wr_next     = 1'b0;
    flip_next      = flip;
    plane_next     = plane;
    row_pair_next  = row_pair;
    col_next       = col;
    phase_next     = phase;
    disp_next      = disp;
    held_data_next = held_data;
    held_row_next  = held_row;
    op_pop         = 1'b0;
    res_push       = 1'b0;
    fw_en          = 1'b0;
    fw_addr        = idx[AW-1:0];
    fw_data        = '0;
    bw_en          = 1'b0;
    bw_addr        = cp_wr_addr;
    bw_data        = front_rd;
    clk_act        = 1'b0;
    lat_act        = 1'b0;
    oe_act         = 1'b0;

    case (state)
      ST_CLEAR: begin
        fw_en   = 1'b1;
        bw_en   = 1'b1;
        bw_addr = idx[AW-1:0];
        bw_data = '0;
        if (idx == (AW + 1)'(DEPTH - 1)) begin
          idx_next   = '0;
          state_next = ST_RUN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_COPY: begin
        // front store read issued in the cycle before its back write
        bw_en = cp_wr;
        if (idx == (AW + 1)'(DEPTH)) begin
          idx_next   = '0;
          state_next = ST_RUN;
        end else begin
          idx_next   = idx + 1'b1;
          cp_wr_next = 1'b1;
        end
      end
      ST_RUN: begin
        if (op_valid) begin
          case (op.cmd)
            CMD_WRITE: begin
              fw_en   = 1'b1;
              fw_addr = {RW'(op.row), CW'(op.column)};
              fw_data = op.pixel;
              op_pop  = 1'b1;
            end
            CMD_FLIP: begin
              flip_next = 1'b1;
              op_pop    = 1'b1;
            end
            CMD_TICK: begin
              if (!res_full) begin
                if (phase == PH_LOW && flip && plane == '0 && row_pair == '0 &&
                    col == '0) begin
                  // frame start with a flip pending: copy, then redo this tick
                  flip_next  = 1'b0;
                  idx_next   = '0;
                  state_next = ST_COPY;
                end else if (phase != PH_LOW || data_ok) begin
                  op_pop   = 1'b1;
                  res_push = 1'b1;
                  case (phase)
                    PH_LOW: begin
                      held_data_next = {plane_bits(bot_rd, plane), plane_bits(top_rd, plane)};
                      phase_next     = PH_HIGH;
                    end
                    PH_HIGH: begin
                      clk_act = 1'b1;
                      if (col_inc >= eff_cols) begin
                        col_next   = '0;
                        disp_next  = '0;
                        phase_next = PH_DISPLAY;
                      end else begin
                        col_next   = col_inc[CW-1:0];
                        phase_next = PH_LOW;
                      end
                    end
                    PH_DISPLAY: begin
                      clk_act       = 1'b1;
                      lat_act       = 1'b1;
                      oe_act        = 1'b1;
                      held_row_next = ROW_ADDR_W'(row_pair);
                      disp_next     = disp_inc[COLOR_BITS-1:0];
                      if (disp_inc >= plane_weight) begin
                        phase_next = PH_BLANK;
                      end
                    end
                    default: begin
                      clk_act = 1'b1;
                      if (row_inc >= half_rows) begin
                        row_pair_next = '0;
                        if (plane == PLANE_W'(COLOR_BITS - 1)) begin
                          plane_next = '0;
                        end else begin
                          plane_next = plane + 1'b1;
                        end
                      end else begin
                        row_pair_next = row_inc[PW-1:0];
                      end
                      disp_next  = '0;
                      phase_next = PH_LOW;
                    end
                  endcase
                end
              end
            end
            default: begin
              op_pop = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_comb begin
    res.top_red       = held_data_next[0];
    res.top_green     = held_data_next[1];
    res.top_blue      = held_data_next[2];
    res.bottom_red    = held_data_next[3];
    res.bottom_green  = held_data_next[4];
    res.bottom_blue   = held_data_next[5];
    res.shift_clock   = clk_act ? cfg.clock_active_high : !cfg.clock_active_high;
    res.row_address   = held_row_next;
    res.latch         = lat_act ? cfg.latch_active_high : !cfg.latch_active_high;
    res.output_enable = oe_act ? cfg.enable_active_high : !cfg.enable_active_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      cp_wr     <= 1'b0;
      flip      <= 1'b0;
      plane     <= '0;
      row_pair  <= '0;
      col       <= '0;
      phase     <= PH_LOW;
      disp      <= '0;
      held_data <= '0;
      held_row  <= '0;
      fresh     <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      cp_wr     <= cp_wr_next;
      flip      <= flip_next;
      plane     <= plane_next;
      row_pair  <= row_pair_next;
      col       <= col_next;
      phase     <= phase_next;
      disp      <= disp_next;
      held_data <= held_data_next;
      held_row  <= held_row_next;
      fresh     <= !bw_en;
    end
  end

  always_ff @(posedge clk) begin
    cp_wr_addr <= idx[AW-1:0];
    rd_top_q   <= pre_top;
    rd_bot_q   <= pre_bot;
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      front_mem[fw_addr] <= fw_data;
    end
    front_rd <= front_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      back_mem[bw_addr] <= bw_data;
    end
    top_rd <= back_mem[pre_top];
    bot_rd <= back_mem[pre_bot];
  end

endmodule
`default_nettype wire

FILE: src/led_matrix_bit_plane_scanner_core.sv
// Bit-plane scanner for a two-half LED matrix panel. Requests come in through a queue
// port: pixel writes into the front frame store, flip requests, and scan ticks; each
// scan tick returns one set of pin levels on the result queue, writes and flips return
// nothing. Writes, flips and scan ticks are each taken as they reach the back end, so the
// scan runs at one tick per clock while the result queue has room. Two cases cost more:
// after reset the front and back stores are swept clear, one entry a cycle, over all
// 2^(clog2(MAX_COLUMNS)+clog2(MAX_ROWS)) entries (4096 at the defaults) with full held
// high; and a scan tick that starts a frame with a flip pending copies the front store
// into the back store through one read and one write port, then reads the back store
// again. A clock-low shift tick also waits when the back-store read issued ahead of it
// no longer matches (after a copy or a change of the row count).
`default_nettype none
module led_matrix_bit_plane_scanner_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         push,
  output logic                                         full,
  input  lmbps_pkg::req_t                              req,
  output logic                                         empty,
  input  logic                                         pop,
  output lmbps_pkg::res_t                              res,
  input  logic                                         cfg_write,
  input  logic [lmbps_pkg::CFG_INDEX_W-1:0]            cfg_index,
  input  logic [lmbps_pkg::CFG_DATA_W-1:0]             cfg_data
);
  import lmbps_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);

  cfg_t          cfg;
  logic [CW:0]   eff_cols;
  logic [RW-1:0] half_rows;
  logic          busy;
  op_t           op;
  logic          op_valid;
  logic          op_pop;
  res_t          back_res;
  logic          res_push;
  logic          res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns_in_use     <= 7'd64;
      cfg.rows_in_use        <= 7'd64;
      cfg.clock_active_high  <= 1'b1;
      cfg.latch_active_high  <= 1'b1;
      cfg.enable_active_high <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLUMNS:    cfg.columns_in_use     <= cfg_data;
        REG_ROWS:       cfg.rows_in_use        <= cfg_data;
        REG_CLOCK_POL:  cfg.clock_active_high  <= cfg_data[0];
        REG_LATCH_POL:  cfg.latch_active_high  <= cfg_data[0];
        REG_ENABLE_POL: cfg.enable_active_high <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the panel size registers to what the stores hold
  always_comb begin
    if (cfg.columns_in_use == '0) begin
      eff_cols = (CW + 1)'(1);
    end else if (32'(cfg.columns_in_use) > 32'(MAX_COLUMNS)) begin
      eff_cols = (CW + 1)'(MAX_COLUMNS);
    end else begin
      eff_cols = (CW + 1)'(cfg.columns_in_use);
    end
  end

  always_comb begin
    if (cfg.rows_in_use < 7'd2) begin
      half_rows = RW'(1);
    end else if (32'(cfg.rows_in_use) > 32'(MAX_ROWS)) begin
      half_rows = RW'(MAX_ROWS / 2);
    end else begin
      half_rows = RW'(cfg.rows_in_use >> 1);
    end
  end

  lmbps_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .busy      (busy),
    .eff_cols  (eff_cols),
    .half_rows (half_rows),
    .op        (op),
    .op_valid  (op_valid),
    .op_pop    (op_pop)
  );

  lmbps_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .eff_cols  (eff_cols),
    .half_rows (half_rows),
    .op        (op),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full),
    .busy      (busy)
  );

  lmbps_fifo #(
    .T     (res_t),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res),
    .empty (empty)
  );

endmodule
`default_nettype wire

FILE: src/lmbps_checker.sv
`default_nettype none
module lmbps_checker (
  input logic            clk,
  input logic            rst,
  input logic            push,
  input logic            full,
  input lmbps_pkg::req_t req,
  input logic            empty,
  input logic            pop,
  input lmbps_pkg::res_t res
);
  import lmbps_pkg::*;

  logic [7:0] outstanding;
  logic       tick_acc;
  logic       res_acc;

  assign tick_acc = push && !full && (req.command == CMD_TICK);
  assign res_acc  = pop && !empty;

  // scan ticks taken but whose pin levels are not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(tick_acc) - 8'(res_acc);
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("requests taken during the clearing pass");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> outstanding != 8'd0)
    else $error("result without a scan tick");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(res))
    else $error("waiting result changed");

endmodule

bind led_matrix_bit_plane_scanner_core lmbps_checker u_checker (.*);
`default_nettype wire

FILE: dv/scan_pin_checker.sv
`timescale 1ns / 100ps
module scan_pin_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  lmbps_pkg::req_t                     req,
  input  logic                                empty,
  input  logic                                pop,
  input  lmbps_pkg::res_t                     res,
  input  logic                                cfg_write,
  input  logic [lmbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lmbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                  errors,
  output int                                  outstanding
);
  import lmbps_pkg::*;

  localparam int PANEL_COLS = 64;
  localparam int PANEL_ROWS = 64;
  localparam int FRAME_SIZE = PANEL_COLS * PANEL_ROWS;

  typedef enum logic [1:0] {CLOCK_LOW, CLOCK_HIGH, DISPLAY, BLANK} scan_phase_e;

  logic [PIX_W-1:0] front_frame [FRAME_SIZE];
  logic [PIX_W-1:0] back_frame [FRAME_SIZE];
  bit               flip_waiting;
  int               plane;
  int               row_pair;
  int               column;
  int               show_count;
  scan_phase_e      scan_phase;
  logic [5:0]       data_lines;
  logic [4:0]       latched_row;

  logic [CFG_DATA_W-1:0] columns_reg;
  logic [CFG_DATA_W-1:0] rows_reg;
  logic                  clock_pol;
  logic                  latch_pol;
  logic                  enable_pol;

  res_t pin_levels_q[$];

  function automatic int active_columns();
    int c;
    c = columns_reg;
    if (c < 1) c = 1;
    if (c > PANEL_COLS) c = PANEL_COLS;
    return c;
  endfunction

  // half the panel height, odd heights round down
  function automatic int active_half();
    int r;
    r = rows_reg;
    if (r < 2) r = 2;
    if (r > PANEL_ROWS) r = PANEL_ROWS;
    return r / 2;
  endfunction

  function automatic logic [PIX_W-1:0] back_pixel(int row, int col);
    if (row >= PANEL_ROWS || col >= PANEL_COLS) return '0;
    return back_frame[row * PANEL_COLS + col];
  endfunction

  function automatic logic [2:0] plane_bits(logic [PIX_W-1:0] px, int p);
    return {px[2 * COLOR_BITS + p], px[COLOR_BITS + p], px[p]};
  endfunction

  task automatic apply_request(req_t r);
    int   cols;
    int   half;
    logic clk_on;
    logic lat_on;
    logic oe_on;
    res_t pins;
    cols = active_columns();
    half = active_half();
    clk_on = 1'b0;
    lat_on = 1'b0;
    oe_on = 1'b0;
    case (r.command)
      CMD_WRITE: begin
        if (int'(r.column) < cols && int'(r.row) < 2 * half)
          front_frame[int'(r.row) * PANEL_COLS + int'(r.column)] = {r.blue, r.green, r.red};
      end
      CMD_FLIP: flip_waiting = 1'b1;
      CMD_TICK: begin
        case (scan_phase)
          CLOCK_LOW: begin
            // frame start takes a pending flip before the first shift
            if (flip_waiting && plane == 0 && row_pair == 0 && column == 0) begin
              back_frame = front_frame;
              flip_waiting = 1'b0;
            end
            data_lines = {plane_bits(back_pixel(row_pair + half, column), plane),
                          plane_bits(back_pixel(row_pair, column), plane)};
            scan_phase = CLOCK_HIGH;
          end
          CLOCK_HIGH: begin
            clk_on = 1'b1;
            column++;
            if (column >= cols) begin
              column = 0;
              show_count = 0;
              scan_phase = DISPLAY;
            end else begin
              scan_phase = CLOCK_LOW;
            end
          end
          DISPLAY: begin
            latched_row = row_pair[4:0];
            clk_on = 1'b1;
            lat_on = 1'b1;
            oe_on = 1'b1;
            show_count++;
            if (show_count >= (1 << plane)) scan_phase = BLANK;
          end
          default: begin
            clk_on = 1'b1;
            row_pair++;
            if (row_pair >= half) begin
              row_pair = 0;
              plane++;
              if (plane >= COLOR_BITS) plane = 0;
            end
            show_count = 0;
            scan_phase = CLOCK_LOW;
          end
        endcase
        pins.top_red = data_lines[0];
        pins.top_green = data_lines[1];
        pins.top_blue = data_lines[2];
        pins.bottom_red = data_lines[3];
        pins.bottom_green = data_lines[4];
        pins.bottom_blue = data_lines[5];
        pins.shift_clock = clk_on ? clock_pol : !clock_pol;
        pins.row_address = latched_row;
        pins.latch = lat_on ? latch_pol : !latch_pol;
        pins.output_enable = oe_on ? enable_pol : !enable_pol;
        pin_levels_q.push_back(pins);
      end
      default: ;
    endcase
  endtask

  task automatic check_pin(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (front_frame[i]) front_frame[i] = '0;
      foreach (back_frame[i]) back_frame[i] = '0;
      flip_waiting = 1'b0;
      plane = 0;
      row_pair = 0;
      column = 0;
      show_count = 0;
      scan_phase = CLOCK_LOW;
      data_lines = '0;
      latched_row = '0;
      columns_reg = 7'd64;
      rows_reg = 7'd64;
      clock_pol = 1'b1;
      latch_pol = 1'b1;
      enable_pol = 1'b0;
      pin_levels_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COLUMNS: columns_reg = cfg_data;
          REG_ROWS: rows_reg = cfg_data;
          REG_CLOCK_POL: clock_pol = cfg_data[0];
          REG_LATCH_POL: latch_pol = cfg_data[0];
          REG_ENABLE_POL: enable_pol = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) apply_request(req);
      if (pop && !empty) begin
        if (pin_levels_q.size() == 0) begin
          $display("%0t: result with no request waiting, expected none got %h", $time, res);
          errors++;
        end else begin
          want = pin_levels_q.pop_front();
          check_pin("top_red", want.top_red, res.top_red);
          check_pin("top_green", want.top_green, res.top_green);
          check_pin("top_blue", want.top_blue, res.top_blue);
          check_pin("bottom_red", want.bottom_red, res.bottom_red);
          check_pin("bottom_green", want.bottom_green, res.bottom_green);
          check_pin("bottom_blue", want.bottom_blue, res.bottom_blue);
          check_pin("shift_clock", want.shift_clock, res.shift_clock);
          check_pin("row_address", want.row_address, res.row_address);
          check_pin("latch", want.latch, res.latch);
          check_pin("output_enable", want.output_enable, res.output_enable);
        end
      end
    end
    outstanding = pin_levels_q.size();
  end

endmodule

FILE: dv/led_matrix_bit_plane_scanner_core_tb.sv
`timescale 1ns / 100ps
module led_matrix_bit_plane_scanner_core_tb;
  import lmbps_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   pop = 1'b0;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  req_t                   req = '0;
  logic                   full;
  logic                   empty;
  res_t                   res;
  int                     errors;
  int                     outstanding;
  int                     stall_cycles = 0;
  bit                     idling = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_matrix_bit_plane_scanner_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scan_pin_checker pin_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // result side stalls at random unless a quiet stretch is running
  always @(negedge clk) begin
    pop <= !rst && !(idling && $urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic req_t make_item(logic [1:0] cmd, int col, int row, int r, int g, int b);
    req_t item;
    item.command = cmd;
    item.column = col[5:0];
    item.row = row[5:0];
    item.red = r[COLOR_BITS-1:0];
    item.green = g[COLOR_BITS-1:0];
    item.blue = b[COLOR_BITS-1:0];
    return item;
  endfunction

  // mostly scan ticks and in-panel writes, with some flips, stray writes and unknown commands
  function automatic req_t random_item(int tick_pct, int cols, int rows);
    req_t item;
    int   pick;
    item = make_item(CMD_WRITE, $urandom_range(63), $urandom_range(63),
                     $urandom_range(2047), $urandom_range(2047), $urandom_range(2047));
    pick = $urandom_range(99);
    if (pick < tick_pct) begin
      item.command = CMD_TICK;
    end else if (pick < tick_pct + 3) begin
      item.command = CMD_FLIP;
    end else if (pick < tick_pct + 5) begin
      item.command = CMD_UNUSED;
    end else if ($urandom_range(99) < 80) begin
      item.column = 6'($urandom_range(cols - 1));
      item.row = 6'($urandom_range(rows - 1));
    end
    return item;
  endfunction

  task automatic send_item(req_t item);
    @(negedge clk);
    while (idling && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req <= item;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[CFG_DATA_W-1:0];
  endtask

  task automatic set_config(int cols, int rows, int clock_hi, int latch_hi, int enable_hi);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_CLOCK_POL, clock_hi);
    write_reg(REG_LATCH_POL, latch_hi);
    write_reg(REG_ENABLE_POL, enable_hi);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(int count, int tick_pct, int cols, int rows, int quiet_items);
    for (int i = 0; i < count; i++) begin
      idling = (i >= quiet_items);
      if (i == count / 2) wait_drained();
      send_item(random_item(tick_pct, cols, rows));
    end
    idling = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // corner pixels of both halves, then a flip taken on the very first tick
    send_item(make_item(CMD_WRITE, 0, 0, 2047, 2047, 2047));
    send_item(make_item(CMD_WRITE, 63, 63, 2047, 0, 1365));
    send_item(make_item(CMD_WRITE, 0, 32, 1365, 2047, 0));
    send_item(make_item(CMD_WRITE, 63, 0, 0, 682, 2047));
    send_item(make_item(CMD_WRITE, 1, 33, 1, 1024, 0));
    send_item(make_item(CMD_WRITE, 1, 1, 1024, 1, 682));
    send_item(make_item(CMD_UNUSED, 5, 5, 2047, 2047, 2047));
    send_item(make_item(CMD_FLIP, 0, 0, 0, 0, 0));
    repeat (8) send_item(make_item(CMD_TICK, 63, 63, 0, 0, 0));
    send_item(make_item(CMD_FLIP, 63, 63, 2047, 2047, 2047));
    send_item(make_item(CMD_TICK, 0, 0, 2047, 2047, 2047));
    run_random(40, 60, 64, 64, 0);

    // smallest panel so whole frames go by and later flips get taken
    set_config(1, 2, 1, 0, 1);
    run_random(2250, 94, 1, 2, 900);

    set_config(3, 6, 0, 1, 0);
    write_reg(REG_UNUSED, 85);
    @(negedge clk);
    cfg_write <= 1'b0;
    // writes just past the panel edge are dropped, the last corner inside is kept
    send_item(make_item(CMD_WRITE, 3, 0, 2047, 2047, 2047));
    send_item(make_item(CMD_WRITE, 0, 6, 2047, 2047, 2047));
    send_item(make_item(CMD_WRITE, 2, 5, 2047, 2047, 2047));
    send_item(make_item(CMD_FLIP, 0, 0, 0, 0, 0));
    run_random(40, 70, 3, 6, 0);

    // register values beyond the allowed range get clamped, and an odd row count rounds down
    set_config(0, 1, 1, 1, 1);
    run_random(25, 70, 1, 2, 0);
    set_config(127, 127, 0, 0, 0);
    run_random(25, 70, 64, 64, 0);
    set_config(64, 5, 1, 0, 0);
    run_random(25, 70, 64, 4, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
